// File: rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types, widths and helpers for the tiled triangle coverage block.
// ----------------------------------------------------------------------------
package ttc_pkg;

    // Default configuration of the block.
    localparam int TILE_SIZE_DEF  = 8;
    localparam int MAX_SCREEN_DEF = 2048;

    // Fixed point format of the vertices.
    localparam int SUB_BITS = 4;
    localparam int SUB      = 1 << SUB_BITS;

    // Field and internal widths.
    localparam int COORD_W = 16;                  // vertex coordinate, signed
    localparam int UCRD_W  = COORD_W - 1;         // on-screen coordinate, unsigned
    localparam int IDX_W   = 8;                   // tile row and column index
    localparam int CFG_W   = 12;                  // screen size registers
    localparam int LIM_W   = CFG_W + SUB_BITS;    // screen limit in subpixels
    localparam int PIX_W   = 13;                  // pixel coordinate, unsigned
    localparam int DW      = COORD_W + 1;         // edge delta, signed
    localparam int OW      = PIX_W + SUB_BITS + 1; // tile origin in subpixels, signed
    localparam int PW      = DW + OW;             // product width, signed
    localparam int EW      = 40;                  // edge function width, signed
    localparam int MASK_W  = 64;
    localparam int CLASS_W = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

    // Tile classification codes.
    typedef enum logic [CLASS_W-1:0] {
        CLASS_REJECT  = 2'd0,
        CLASS_SKIP    = 2'd1,
        CLASS_PARTIAL = 2'd2,
        CLASS_FULL    = 2'd3
    } t_tile_class;

    // Registered input request.
    typedef struct packed {
        logic                            valid;
        logic [2:0][COORD_W-1:0]         vx;
        logic [2:0][COORD_W-1:0]         vy;
        logic [IDX_W-1:0]                col;
        logic [IDX_W-1:0]                row;
    } t_tri_in;

    // Result of the setup stage: rejection, bounding box and edge products.
    typedef struct packed {
        logic                            valid;
        logic                            reject;
        logic                            outside;
        logic [2:0][DW-1:0]              dx;
        logic [2:0][DW-1:0]              dy;
        logic [2:0]                      bias;
        logic [2:0][PW-1:0]              pa;
        logic [2:0][PW-1:0]              pb;
        logic [2:0][PW-1:0]              pc;
        logic [2:0][PW-1:0]              pd;
    } t_setup;

    // Edge functions evaluated at the tile origin.
    typedef struct packed {
        logic                            valid;
        logic                            reject;
        logic                            outside;
        logic [2:0][EW-1:0]              e00;
        logic [2:0][DW-1:0]              dx;
        logic [2:0][DW-1:0]              dy;
    } t_edge;

    // Sign extension of a product to the edge function width.
    function automatic logic signed [EW-1:0] sext_p(input logic [PW-1:0] v);
        return {{(EW-PW){v[PW-1]}}, v};
    endfunction

    // Sign extension of an edge delta to the edge function width.
    function automatic logic signed [EW-1:0] sext_d(input logic [DW-1:0] v);
        return {{(EW-DW){v[DW-1]}}, v};
    endfunction

endpackage

// File: rtl/ttc_setup.sv
// ----------------------------------------------------------------------------
// ttc_setup
// First pipeline stage: screen rejection, bounding box test, edge deltas and
// the partial products of the edge functions at the tile origin.
// ----------------------------------------------------------------------------
module ttc_setup #(
    parameter int TILE_SIZE  = ttc_pkg::TILE_SIZE_DEF,
    parameter int MAX_SCREEN = ttc_pkg::MAX_SCREEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ttc_pkg::t_tri_in           i_tri,
    input  logic [ttc_pkg::CFG_W-1:0]  i_screen_width,
    input  logic [ttc_pkg::CFG_W-1:0]  i_screen_height,
    output ttc_pkg::t_setup            o_setup
);
    import ttc_pkg::*;

    t_setup r_setup, n_setup;

    logic [CFG_W-1:0]         w_clamp, h_clamp;
    logic [LIM_W-1:0]         x_lim, y_lim;
    logic [2:0]               off;
    logic [UCRD_W-1:0]        min_x, max_x, min_y, max_y;
    logic [PIX_W-1:0]         min_px, max_px, min_py, max_py;
    logic [PIX_W-1:0]         tx, ty, tx_last, ty_last;
    logic signed [OW-1:0]     x0, y0;
    logic signed [DW-1:0]     dxs, dys;
    logic signed [COORD_W-1:0] xa, ya, xb, yb;
    logic signed [PW-1:0]     pa, pb, pc, pd;
    logic [UCRD_W:0]          sum_lo_x, sum_hi_x, sum_lo_y, sum_hi_y;
    int                       j;

    always_comb begin
        n_setup = r_setup;
        n_setup.valid = i_tri.valid;

        // Screen limits in subpixels, with the size clamped to the maximum.
        w_clamp = (i_screen_width > CFG_W'(MAX_SCREEN)) ? CFG_W'(MAX_SCREEN)
                                                        : i_screen_width;
        h_clamp = (i_screen_height > CFG_W'(MAX_SCREEN)) ? CFG_W'(MAX_SCREEN)
                                                         : i_screen_height;
        x_lim = {w_clamp, {SUB_BITS{1'b0}}};
        y_lim = {h_clamp, {SUB_BITS{1'b0}}};

        // A negative coordinate or one at or past the limit rejects.
        for (int v = 0; v < 3; v++) begin
            off[v] = i_tri.vx[v][COORD_W-1] | i_tri.vy[v][COORD_W-1]
                   | (i_tri.vx[v] >= x_lim) | (i_tri.vy[v] >= y_lim);
        end
        n_setup.reject = |off;

        // Extremes of the vertices, valid once the triangle is on screen.
        min_x = i_tri.vx[0][UCRD_W-1:0];
        max_x = i_tri.vx[0][UCRD_W-1:0];
        min_y = i_tri.vy[0][UCRD_W-1:0];
        max_y = i_tri.vy[0][UCRD_W-1:0];
        for (int v = 1; v < 3; v++) begin
            if (i_tri.vx[v][UCRD_W-1:0] < min_x) min_x = i_tri.vx[v][UCRD_W-1:0];
            if (i_tri.vx[v][UCRD_W-1:0] > max_x) max_x = i_tri.vx[v][UCRD_W-1:0];
            if (i_tri.vy[v][UCRD_W-1:0] < min_y) min_y = i_tri.vy[v][UCRD_W-1:0];
            if (i_tri.vy[v][UCRD_W-1:0] > max_y) max_y = i_tri.vy[v][UCRD_W-1:0];
        end

        // Round the extremes up to whole pixels.
        sum_lo_x = {1'b0, min_x} + (UCRD_W+1)'(SUB - 1);
        sum_hi_x = {1'b0, max_x} + (UCRD_W+1)'(SUB - 1);
        sum_lo_y = {1'b0, min_y} + (UCRD_W+1)'(SUB - 1);
        sum_hi_y = {1'b0, max_y} + (UCRD_W+1)'(SUB - 1);
        min_px = PIX_W'(sum_lo_x >> SUB_BITS);
        max_px = PIX_W'(sum_hi_x >> SUB_BITS);
        min_py = PIX_W'(sum_lo_y >> SUB_BITS);
        max_py = PIX_W'(sum_hi_y >> SUB_BITS);

        // Tile origin in pixels and the last pixel of the tile.
        tx      = PIX_W'(i_tri.col) * PIX_W'(TILE_SIZE);
        ty      = PIX_W'(i_tri.row) * PIX_W'(TILE_SIZE);
        tx_last = tx + PIX_W'(TILE_SIZE - 1);
        ty_last = ty + PIX_W'(TILE_SIZE - 1);

        // The box start rounded down to a tile boundary lies above the origin
        // exactly when the last pixel of the tile lies below the unrounded start.
        n_setup.outside = (tx_last < min_px) || (tx >= max_px)
                       || (ty_last < min_py) || (ty >= max_py);

        x0 = $signed({1'b0, tx, {SUB_BITS{1'b0}}});
        y0 = $signed({1'b0, ty, {SUB_BITS{1'b0}}});

        // Edge e runs from vertex e to the next vertex around the triangle.
        for (int e = 0; e < 3; e++) begin
            j   = (e == 2) ? 0 : e + 1;
            xa  = $signed(i_tri.vx[e]);
            ya  = $signed(i_tri.vy[e]);
            xb  = $signed(i_tri.vx[j]);
            yb  = $signed(i_tri.vy[j]);
            dxs = DW'(xa) - DW'(xb);
            dys = DW'(ya) - DW'(yb);
            pa  = PW'(dys) * PW'(xa);
            pb  = PW'(dxs) * PW'(ya);
            pc  = PW'(dxs) * PW'(y0);
            pd  = PW'(dys) * PW'(x0);
            n_setup.dx[e]   = dxs;
            n_setup.dy[e]   = dys;
            n_setup.bias[e] = (dys < 0) || ((dys == 0) && (dxs > 0));
            n_setup.pa[e]   = pa;
            n_setup.pb[e]   = pb;
            n_setup.pc[e]   = pc;
            n_setup.pd[e]   = pd;
        end
    end

    // Stage register; only the valid flag is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup.valid <= 1'b0;
        end else begin
            r_setup <= n_setup;
        end
    end

    assign o_setup = r_setup;

endmodule

// File: rtl/ttc_edge.sv
// ----------------------------------------------------------------------------
// ttc_edge
// Second pipeline stage: sums the partial products into the edge function of
// each triangle edge at the tile origin, including the top-left fill bias.
// ----------------------------------------------------------------------------
module ttc_edge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttc_pkg::t_setup  i_setup,
    output ttc_pkg::t_edge   o_edge
);
    import ttc_pkg::*;

    t_edge r_edge, n_edge;

    logic signed [EW-1:0] bias_ext;

    always_comb begin
        n_edge         = r_edge;
        n_edge.valid   = i_setup.valid;
        n_edge.reject  = i_setup.reject;
        n_edge.outside = i_setup.outside;
        n_edge.dx      = i_setup.dx;
        n_edge.dy      = i_setup.dy;
        bias_ext       = '0;
        for (int e = 0; e < 3; e++) begin
            bias_ext      = $signed({{(EW-1){1'b0}}, i_setup.bias[e]});
            n_edge.e00[e] = sext_p(i_setup.pa[e]) - sext_p(i_setup.pb[e])
                          + sext_p(i_setup.pc[e]) - sext_p(i_setup.pd[e])
                          + bias_ext;
        end
    end

    // Stage register; only the valid flag is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge.valid <= 1'b0;
        end else begin
            r_edge <= n_edge;
        end
    end

    assign o_edge = r_edge;

endmodule

// File: rtl/ttc_cover.sv
// ----------------------------------------------------------------------------
// ttc_cover
// Last pipeline stage: tests every pixel of the tile against each triangle edge,
// classifies the tile from its corners and registers the result.
// ----------------------------------------------------------------------------
module ttc_cover #(
    parameter int TILE_SIZE = ttc_pkg::TILE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttc_pkg::t_edge               i_edge,
    output logic                         o_done,
    output logic [ttc_pkg::MASK_W-1:0]   o_coverage_mask,
    output logic [ttc_pkg::CLASS_W-1:0]  o_tile_class
);
    import ttc_pkg::*;

    localparam int Q = TILE_SIZE;
    localparam logic [MASK_W-1:0] FULL_MASK =
        (Q * Q >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << (Q * Q)) - MASK_W'(1));

    logic                 r_done;
    logic [MASK_W-1:0]    r_mask, n_mask;
    t_tile_class          r_class, n_class;

    logic signed [EW-1:0] rowv [3][Q];
    logic signed [EW-1:0] colv [3][Q];
    logic signed [EW-1:0] dx_e, dy_e;
    logic [2:0][MASK_W-1:0] in_mask;
    logic [2:0]           any_c, all_c;
    logic [MASK_W-1:0]    cov;

    // Edge value at pixel (k, r) is the origin value plus sixteen times
    // (dx * r - dy * k); the row part and the column part are formed apart.
    always_comb begin
        in_mask = '0;
        for (int e = 0; e < 3; e++) begin
            dx_e = sext_d(i_edge.dx[e]);
            dy_e = sext_d(i_edge.dy[e]);
            for (int r = 0; r < Q; r++) begin
                rowv[e][r] = $signed(i_edge.e00[e]) + ((dx_e * EW'(r)) <<< SUB_BITS);
                colv[e][r] = (dy_e * EW'(r)) <<< SUB_BITS;
            end
            for (int r = 0; r < Q; r++) begin
                for (int k = 0; k < Q; k++) begin
                    in_mask[e][r*Q+k] = rowv[e][r] > colv[e][k];
                end
            end
        end
    end

    // Corner tests and classification.
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            any_c[e] = in_mask[e][0] | in_mask[e][Q-1]
                     | in_mask[e][(Q-1)*Q] | in_mask[e][Q*Q-1];
            all_c[e] = in_mask[e][0] & in_mask[e][Q-1]
                     & in_mask[e][(Q-1)*Q] & in_mask[e][Q*Q-1];
        end
        cov = in_mask[0] & in_mask[1] & in_mask[2];

        if (i_edge.reject) begin
            n_class = CLASS_REJECT;
            n_mask  = '0;
        end else if (i_edge.outside || !(&any_c)) begin
            n_class = CLASS_SKIP;
            n_mask  = '0;
        end else if (&all_c) begin
            n_class = CLASS_FULL;
            n_mask  = FULL_MASK;
        end else begin
            n_class = CLASS_PARTIAL;
            n_mask  = cov;
        end
    end

    // Result register; the strobe is the only control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_edge.valid;
            if (i_edge.valid) begin
                r_mask  <= n_mask;
                r_class <= n_class;
            end
        end
    end

    assign o_done          = r_done;
    assign o_coverage_mask = r_mask;
    assign o_tile_class    = r_class;

endmodule

// File: rtl/tiled_triangle_coverage.sv
// ----------------------------------------------------------------------------
// tiled_triangle_coverage
// Half-space coverage of one pixel tile by one triangle, one request a cycle.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  request   in         start, busy          i_v1_x .. i_v3_y, i_tile_col/row
//  result    out        o_done (strobe)      o_coverage_mask, o_tile_class
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A request is taken on every cycle in which start is high; busy stays low.
// Each request's path to the ports holds four registers: input, setup,
// edge sum, and pixel test with result.
// The throughput of one request per cycle is set by that pipeline.
// Reset clears the configuration to 640 by 480 and drops requests in flight.
// Results are shown for a single cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module tiled_triangle_coverage #(
    parameter int TILE_SIZE  = ttc_pkg::TILE_SIZE_DEF,
    parameter int MAX_SCREEN = ttc_pkg::MAX_SCREEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v1_x,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v1_y,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v2_x,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v2_y,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v3_x,
    input  logic signed [ttc_pkg::COORD_W-1:0] i_v3_y,
    input  logic [ttc_pkg::IDX_W-1:0]      i_tile_col,
    input  logic [ttc_pkg::IDX_W-1:0]      i_tile_row,
    input  logic                           i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttc_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_done,
    output logic [ttc_pkg::MASK_W-1:0]     o_coverage_mask,
    output logic [ttc_pkg::CLASS_W-1:0]    o_tile_class
);
    import ttc_pkg::*;

    logic [CFG_W-1:0] r_screen_width, r_screen_height;
    t_tri_in          r_tri, n_tri;
    t_setup           setup;
    t_edge            edge_q;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register; a request is taken whenever start is high.
    always_comb begin
        n_tri.valid = start && !busy;
        n_tri.vx    = {i_v3_x, i_v2_x, i_v1_x};
        n_tri.vy    = {i_v3_y, i_v2_y, i_v1_y};
        n_tri.col   = i_tile_col;
        n_tri.row   = i_tile_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri.valid <= 1'b0;
        end else begin
            r_tri <= n_tri;
        end
    end

    assign busy = 1'b0;

    ttc_setup #(
        .TILE_SIZE  (TILE_SIZE),
        .MAX_SCREEN (MAX_SCREEN)
    ) u_setup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tri           (r_tri),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_setup         (setup)
    );

    ttc_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_setup (setup),
        .o_edge  (edge_q)
    );

    ttc_cover #(
        .TILE_SIZE (TILE_SIZE)
    ) u_cover (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_edge          (edge_q),
        .o_done          (o_done),
        .o_coverage_mask (o_coverage_mask),
        .o_tile_class    (o_tile_class)
    );

endmodule

// File: rtl/ttc_checker.sv
// ----------------------------------------------------------------------------
// ttc_checker
// Port-level checks on request latency and on the shape of the results.
// ----------------------------------------------------------------------------
module ttc_checker #(
    parameter int TILE_SIZE = ttc_pkg::TILE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic [ttc_pkg::MASK_W-1:0]    o_coverage_mask,
    input  logic [ttc_pkg::CLASS_W-1:0]   o_tile_class
);
    import ttc_pkg::*;

    localparam int Q = TILE_SIZE;
    localparam logic [MASK_W-1:0] FULL_MASK =
        (Q * Q >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << (Q * Q)) - MASK_W'(1));

    // Every request gives a result once it has passed the input, setup, edge and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##4 o_done)
        else $error("request without a result four cycles later");

    // No result appears without a request taken before it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 4))
        else $error("result without a matching request");

    // Rejected and skipped tiles carry an empty mask.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_tile_class == CLASS_REJECT || o_tile_class == CLASS_SKIP)
        |-> o_coverage_mask == '0)
        else $error("rejected or skipped tile with coverage");

    // Full tiles cover the whole tile; no mask reaches past the tile.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_tile_class == CLASS_FULL |-> o_coverage_mask == FULL_MASK)
        else $error("full tile without a complete mask");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_coverage_mask & ~FULL_MASK) == '0)
        else $error("coverage outside the tile");

endmodule

bind tiled_triangle_coverage ttc_checker #(
    .TILE_SIZE (TILE_SIZE)
) u_ttc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_coverage_mask (o_coverage_mask),
    .o_tile_class    (o_tile_class)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tiled triangle coverage block. Requests are
// predicted on acceptance by an independent half-space coverage model and
// each strobed result is compared against the oldest prediction. The run
// walks through directed corner cases, then random triangles on several
// screen sizes with varying request gaps.
// ----------------------------------------------------------------------------
module tb;
    import ttc_pkg::*;

    localparam int TILE        = TILE_SIZE_DEF;
    localparam int CYCLE_LIMIT = 200000;

    // One triangle request: three vertices and a tile index.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] vx;
        logic [2:0][COORD_W-1:0] vy;
        logic [IDX_W-1:0]        col;
        logic [IDX_W-1:0]        row;
    } t_tri_req;

    // One predicted coverage result.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        t_tile_class       cls;
    } t_coverage;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_W-1:0]    i_v1_x;
    logic [COORD_W-1:0]    i_v1_y;
    logic [COORD_W-1:0]    i_v2_x;
    logic [COORD_W-1:0]    i_v2_y;
    logic [COORD_W-1:0]    i_v3_x;
    logic [COORD_W-1:0]    i_v3_y;
    logic [IDX_W-1:0]      i_tile_col;
    logic [IDX_W-1:0]      i_tile_row;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  o_done;
    logic [MASK_W-1:0]     o_coverage_mask;
    logic [CLASS_W-1:0]    o_tile_class;

    // Screen size as the block should currently hold it.
    logic [CFG_W-1:0]      scr_w;
    logic [CFG_W-1:0]      scr_h;

    t_coverage             pending_q[$];
    t_coverage             oldest;
    int                    mismatch_count = 0;
    int                    sent_count;
    int                    checked_count = 0;
    int                    class_seen[4] = '{0, 0, 0, 0};
    int                    cycle_count = 0;

    tiled_triangle_coverage dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_v1_x          (i_v1_x),
        .i_v1_y          (i_v1_y),
        .i_v2_x          (i_v2_x),
        .i_v2_y          (i_v2_y),
        .i_v3_x          (i_v3_x),
        .i_v3_y          (i_v3_y),
        .i_tile_col      (i_tile_col),
        .i_tile_row      (i_tile_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_coverage_mask (o_coverage_mask),
        .o_tile_class    (o_tile_class)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tiled_triangle_coverage");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Coverage prediction
    // ------------------------------------------------------------------

    function automatic longint min3(longint a, longint b, longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint max3(longint a, longint b, longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // A sample point is covered by an edge when its edge function is positive.
    function automatic bit edge_inside(longint c, longint dx, longint dy,
                                       longint x, longint y);
        return (c + dx * y - dy * x) > 0;
    endfunction

    function automatic t_coverage predict_coverage(t_tri_req r);
        t_coverage  res;
        longint     xs[3], ys[3], dx[3], dy[3], ec[3];
        longint     w, h, minx, maxx, miny, maxy, tx, ty, x0, x1, y0, y1, px, py;
        logic [3:0] corner[3];
        int         i, j, rr, k;
        w = (scr_w > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : scr_w;
        h = (scr_h > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : scr_h;
        res.mask = '0;
        res.cls  = CLASS_REJECT;
        for (i = 0; i < 3; i++) begin
            xs[i] = $signed(r.vx[i]);
            ys[i] = $signed(r.vy[i]);
        end
        // Any vertex off the screen rejects the whole triangle.
        for (i = 0; i < 3; i++) begin
            if (xs[i] < 0 || ys[i] < 0 || xs[i] >= w * SUB || ys[i] >= h * SUB)
                return res;
        end
        // Edge constants, with the top-left fill bias folded in.
        for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            dx[i] = xs[i] - xs[j];
            dy[i] = ys[i] - ys[j];
            ec[i] = dy[i] * xs[i] - dx[i] * ys[i];
            if (dy[i] < 0 || (dy[i] == 0 && dx[i] > 0))
                ec[i] = ec[i] + 1;
        end
        // Pixel-rounded bounding box, start snapped down to the tile grid.
        minx = (min3(xs[0], xs[1], xs[2]) + SUB - 1) / SUB;
        maxx = (max3(xs[0], xs[1], xs[2]) + SUB - 1) / SUB;
        miny = (min3(ys[0], ys[1], ys[2]) + SUB - 1) / SUB;
        maxy = (max3(ys[0], ys[1], ys[2]) + SUB - 1) / SUB;
        minx = minx - (minx % TILE);
        miny = miny - (miny % TILE);
        tx = longint'(r.col) * TILE;
        ty = longint'(r.row) * TILE;
        res.cls = CLASS_SKIP;
        if (tx < minx || tx >= maxx || ty < miny || ty >= maxy)
            return res;
        // Tile corners against each edge.
        x0 = tx * SUB;
        x1 = (tx + TILE - 1) * SUB;
        y0 = ty * SUB;
        y1 = (ty + TILE - 1) * SUB;
        for (i = 0; i < 3; i++) begin
            corner[i] = {edge_inside(ec[i], dx[i], dy[i], x1, y1),
                         edge_inside(ec[i], dx[i], dy[i], x0, y1),
                         edge_inside(ec[i], dx[i], dy[i], x1, y0),
                         edge_inside(ec[i], dx[i], dy[i], x0, y0)};
        end
        if (corner[0] == 4'h0 || corner[1] == 4'h0 || corner[2] == 4'h0)
            return res;
        if (corner[0] == 4'hF && corner[1] == 4'hF && corner[2] == 4'hF) begin
            res.cls  = CLASS_FULL;
            res.mask = '1;
            return res;
        end
        // Partial tile: test every pixel sample.
        res.cls = CLASS_PARTIAL;
        for (rr = 0; rr < TILE; rr++) begin
            for (k = 0; k < TILE; k++) begin
                px = (tx + k) * SUB;
                py = (ty + rr) * SUB;
                if (edge_inside(ec[0], dx[0], dy[0], px, py) &&
                    edge_inside(ec[1], dx[1], dy[1], px, py) &&
                    edge_inside(ec[2], dx[2], dy[2], px, py))
                    res.mask[rr * TILE + k] = 1'b1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Every strobed result is matched against the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            class_seen[o_tile_class]++;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no request outstanding",
                                o_coverage_mask, '0);
            end else begin
                oldest = pending_q.pop_front();
                checked_count++;
                if (o_tile_class !== oldest.cls)
                    report_mismatch("tile class", o_tile_class, oldest.cls);
                if (o_coverage_mask !== oldest.mask)
                    report_mismatch("coverage mask", o_coverage_mask, oldest.mask);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it.
    task automatic send_request(t_tri_req r);
        @(negedge i_clk);
        start      <= 1'b1;
        i_v1_x     <= r.vx[0];
        i_v1_y     <= r.vy[0];
        i_v2_x     <= r.vx[1];
        i_v2_y     <= r.vy[1];
        i_v3_x     <= r.vx[2];
        i_v3_y     <= r.vy[2];
        i_tile_col <= r.col;
        i_tile_row <= r.row;
        do @(posedge i_clk); while (busy);
        pending_q = {pending_q, predict_coverage(r)};
        sent_count++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Rewrite both screen registers once the pipeline is empty.
    task automatic configure_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        scr_w = w;
        @(negedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        scr_h = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_tri_req make_request(int x1, int y1, int x2, int y2,
                                              int x3, int y3, int col, int row);
        t_tri_req r;
        r.vx[0] = COORD_W'(x1);
        r.vy[0] = COORD_W'(y1);
        r.vx[1] = COORD_W'(x2);
        r.vy[1] = COORD_W'(y2);
        r.vx[2] = COORD_W'(x3);
        r.vy[2] = COORD_W'(y3);
        r.col   = IDX_W'(col);
        r.row   = IDX_W'(row);
        return r;
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly on-screen triangles of mixed size with a tile near their box,
    // some with one vertex pushed off the screen, and some pure noise.
    task automatic make_random_request(output t_tri_req r);
        int     spreads[6];
        longint limx, limy, s, cx, cy, v, lo, hi, lim;
        int     kind, i, bad;
        spreads = '{8, 40, 160, 800, 4000, 40000};
        limx = ((scr_w > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : scr_w) * SUB;
        limy = ((scr_h > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : scr_h) * SUB;
        if (limx > 32768) limx = 32768;
        if (limy > 32768) limy = 32768;
        kind = $urandom_range(0, 99);
        if (limx == 0 || limy == 0 || kind < 10) begin
            for (i = 0; i < 3; i++) begin
                r.vx[i] = COORD_W'($urandom);
                r.vy[i] = COORD_W'($urandom);
            end
            r.col = IDX_W'($urandom);
            r.row = IDX_W'($urandom);
            return;
        end
        s  = spreads[$urandom_range(0, 5)];
        cx = $urandom_range(0, int'(limx - 1));
        cy = $urandom_range(0, int'(limy - 1));
        for (i = 0; i < 3; i++) begin
            v = cx + longint'($urandom_range(0, int'(2 * s))) - s;
            r.vx[i] = COORD_W'(clamp_range(v, 0, limx - 1));
            v = cy + longint'($urandom_range(0, int'(2 * s))) - s;
            r.vy[i] = COORD_W'(clamp_range(v, 0, limy - 1));
        end
        // Broken triangle: one coordinate just or far off the screen.
        if (kind < 22) begin
            bad = $urandom_range(0, 5);
            lim = (bad % 2 == 0) ? limx : limy;
            case ($urandom_range(0, 3))
                0: v = -1;
                1: v = -longint'($urandom_range(1, 32768));
                2: v = (lim <= 32767) ? lim : -1;
                default: v = (lim <= 32767) ? lim + $urandom_range(0, int'(32767 - lim))
                                            : -2;
            endcase
            if (bad % 2 == 0) r.vx[bad / 2] = COORD_W'(v);
            else              r.vy[bad / 2] = COORD_W'(v);
        end
        // Tile chosen within one tile of the pixel bounding box.
        lo = min3($signed(r.vx[0]), $signed(r.vx[1]), $signed(r.vx[2])) / SUB / TILE - 1;
        hi = (max3($signed(r.vx[0]), $signed(r.vx[1]), $signed(r.vx[2])) + SUB - 1)
             / SUB / TILE + 1;
        lo = clamp_range(lo, 0, 255);
        hi = clamp_range(hi, 0, 255);
        r.col = IDX_W'($urandom_range(int'(lo), int'(hi)));
        lo = min3($signed(r.vy[0]), $signed(r.vy[1]), $signed(r.vy[2])) / SUB / TILE - 1;
        hi = (max3($signed(r.vy[0]), $signed(r.vy[1]), $signed(r.vy[2])) + SUB - 1)
             / SUB / TILE + 1;
        lo = clamp_range(lo, 0, 255);
        hi = clamp_range(hi, 0, 255);
        r.row = IDX_W'($urandom_range(int'(lo), int'(hi)));
    endtask

    // Random requests; gaps come in bursts with gap-free stretches between.
    task automatic run_random_requests(int count, int idle_pct);
        t_tri_req r;
        int       n;
        for (n = 0; n < count; n++) begin
            make_random_request(r);
            send_request(r);
            if (idle_pct > 0 && ((n / 16) % 4) != 0 && $urandom_range(0, 99) < idle_pct)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases on the reset screen of 640 by 480.
    task automatic test_directed_cases();
        // Off-screen vertices on each side, and the field extremes.
        send_request(make_request(-1, 100, 500, 100, 100, 500, 0, 0));
        send_request(make_request(100, -32768, 500, 100, 100, 500, 0, 0));
        send_request(make_request(100, 100, 10240, 100, 100, 500, 0, 0));
        send_request(make_request(100, 100, 500, 100, 100, 7680, 0, 0));
        send_request(make_request(32767, 32767, 0, 0, 0, 0, 255, 255));
        // Large right triangle in both windings: full tile or skipped.
        send_request(make_request(0, 0, 7000, 0, 0, 7000, 1, 1));
        send_request(make_request(0, 0, 0, 7000, 7000, 0, 1, 1));
        // Tile cut by the hypotenuse.
        send_request(make_request(0, 0, 7000, 0, 0, 7000, 27, 27));
        send_request(make_request(0, 0, 0, 7000, 7000, 0, 27, 27));
        // Tile outside the box, and inside the box but beyond an edge.
        send_request(make_request(0, 0, 7000, 0, 0, 7000, 100, 100));
        send_request(make_request(0, 0, 7000, 0, 0, 7000, 50, 50));
        // Edges through pixel samples, where the fill bias decides.
        send_request(make_request(0, 0, 128, 0, 0, 128, 0, 0));
        send_request(make_request(0, 0, 0, 128, 128, 0, 0, 0));
        // Triangle between samples: partial tile with an empty mask.
        send_request(make_request(17, 17, 30, 17, 17, 30, 0, 0));
        send_request(make_request(17, 17, 17, 30, 30, 17, 0, 0));
        // Vertices on the last valid subpixel of the screen.
        send_request(make_request(10239, 7679, 0, 7679, 10239, 0, 79, 59));
        send_request(make_request(10239, 7679, 10239, 0, 0, 7679, 79, 59));
        send_request(make_request(10239, 7679, 0, 7679, 10239, 0, 0, 0));
        // Degenerate triangle collapsed to one point.
        send_request(make_request(160, 160, 160, 160, 160, 160, 1, 1));
    endtask

    // Largest screen: every non-negative coordinate is on it.
    task automatic test_wide_screen();
        configure_screen(12'd2048, 12'd2048);
        run_random_requests(100, 0);
    endtask

    // Register values above the maximum are clamped by the block.
    task automatic test_clamped_screen();
        configure_screen(12'd4095, 12'd4095);
        run_random_requests(80, 76);
    endtask

    // Single-pixel screen.
    task automatic test_tiny_screen();
        configure_screen(12'd1, 12'd1);
        run_random_requests(30, 32);
    endtask

    // A zero dimension rejects every triangle.
    task automatic test_zero_screen();
        configure_screen(12'd0, 12'd2048);
        run_random_requests(20, 32);
    endtask

    // Reset size written back, with a full drain part way through.
    task automatic test_default_screen();
        configure_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
        run_random_requests(50, 32);
        wait_drain();
        run_random_requests(50, 0);
    endtask

    // Arbitrary screen sizes.
    task automatic test_random_screens();
        int p;
        for (p = 0; p < 4; p++) begin
            configure_screen(CFG_W'($urandom_range(1, 4095)),
                             CFG_W'($urandom_range(1, 4095)));
            run_random_requests(40, 76);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_v1_x         = '0;
        i_v1_y         = '0;
        i_v2_x         = '0;
        i_v2_y         = '0;
        i_v3_x         = '0;
        i_v3_y         = '0;
        i_tile_col     = '0;
        i_tile_row     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_SCREEN_WIDTH;
        i_cfg_data     = '0;
        scr_w          = SCREEN_WIDTH_RST;
        scr_h          = SCREEN_HEIGHT_RST;
        sent_count     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_wide_screen();
        test_clamped_screen();
        test_tiny_screen();
        test_zero_screen();
        test_default_screen();
        test_random_screens();

        // Let the pipeline empty, then keep the clock running to catch stray strobes.
        wait_drain();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d requests on nine screen settings, %0d results checked.",
                 sent_count, checked_count);
        $display("Classes seen: rejected %0d, skipped %0d, partial %0d, full %0d.",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
        if (mismatch_count == 0)
            $display("PASS tiled_triangle_coverage");
        else
            $display("FAIL tiled_triangle_coverage");
        $finish;
    end

endmodule
